FILE: rtl/core/mm3_pkg.sv
package mm3_pkg;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;
  localparam logic [31:0] MIX_MUL5 = 32'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_ADD,
    ST_TAIL,
    ST_FIN1,
    ST_FIN2
  } state_t;

  typedef enum logic [2:0] {
    K_C1,
    K_C2,
    K_MUL5,
    K_F1,
    K_F2
  } mul_k_t;

  typedef struct packed {
    logic        en;
    mul_k_t      k;
    logic [31:0] a;
  } mul_req_t;

  function automatic logic [31:0] tail_mask(input logic [1:0] cnt);
    logic [31:0] m;
    unique case (cnt)
      2'd1:    m = 32'h000000ff;
      2'd2:    m = 32'h0000ffff;
      2'd3:    m = 32'h00ffffff;
      default: m = 32'hffffffff;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/murmur3_32_hash_stream_unit.sv
// A full word runs mix steps MIX1, MIX2, MIX3 and ADD, a partial word MIX1, MIX2 and TAIL,
// all on the one shared constant multiplier; an empty word skips them. A last item then
// runs FIN1 and FIN2. A new item is taken only while the sequencer is idle.
// The next item is taken while a finished hash waits in the output register; a second
// finished hash waits in the product register and stalls the input until that register frees.
// Reset (rst_n low, synchronous) clears seed to zero, idles the sequencer, drops any result.
module murmur3_32_hash_stream_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  logic [31:0]       seed_r;
  mm3_pkg::mul_req_t mul_req;
  logic [31:0]       prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  mm3_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (seed_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .mul_req        (mul_req),
    .prod           (prod)
  );

  mm3_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

endmodule

FILE: rtl/core/mm3_mul.sv
module mm3_mul (
  input  logic              clk,
  input  mm3_pkg::mul_req_t req,
  output logic [31:0]       prod_r
);

  logic [31:0] kval;
  logic [31:0] prod_nxt;

  always_comb begin
    unique case (req.k)
      mm3_pkg::K_C1:   kval = mm3_pkg::MIX_C1;
      mm3_pkg::K_C2:   kval = mm3_pkg::MIX_C2;
      mm3_pkg::K_MUL5: kval = mm3_pkg::MIX_MUL5;
      mm3_pkg::K_F1:   kval = mm3_pkg::FIN_C1;
      mm3_pkg::K_F2:   kval = mm3_pkg::FIN_C2;
      default:         kval = mm3_pkg::MIX_C1;
    endcase
  end

  assign prod_nxt = req.a * kval;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

FILE: rtl/core/mm3_seq.sv
module mm3_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       seed,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_data_word,
  input  logic [2:0]        in_byte_count,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_hash_value,
  output mm3_pkg::mul_req_t mul_req,
  input  logic [31:0]       prod
);

  mm3_pkg::state_t state_r, state_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] word_r, word_nxt;
  logic        last_r, last_nxt;
  logic        full_r, full_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;
  logic        pend_r, pend_nxt;

  logic        accept;
  logic [2:0]  cnt;
  logic [31:0] h_start;
  logic [31:0] len_start;
  logic [31:0] mix_x;
  logic [31:0] fin_x;
  logic [31:0] fin_a;
  logic [31:0] fin_b;
  logic [31:0] fin_h;
  logic        out_free;

  assign in_stall = (state_r != mm3_pkg::ST_IDLE) || (pend_r && !out_free);
  assign accept   = in_valid && !in_stall;
  assign cnt      = in_byte_count[2] ? 3'd4 : in_byte_count;
  assign h_start  = in_msg_r ? h_r : seed;
  assign len_start = in_msg_r ? len_r : 32'd0;
  assign out_free = !out_valid_r || !out_stall;

  assign mix_x = h_r ^ prod;
  assign fin_x = h_r ^ len_r;
  assign fin_a = fin_x ^ (fin_x >> 16);
  assign fin_b = prod ^ (prod >> 13);
  assign fin_h = prod ^ (prod >> 16);

  always_comb begin
    state_nxt     = state_r;
    in_msg_nxt    = in_msg_r;
    h_nxt         = h_r;
    len_nxt       = len_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hash_nxt  = out_hash_r;
    mul_req.en    = 1'b0;
    mul_req.k     = mm3_pkg::K_C1;
    mul_req.a     = word_r;

    unique case (state_r)
      mm3_pkg::ST_IDLE: begin
        if (accept) begin
          h_nxt      = h_start;
          len_nxt    = len_start + {29'd0, cnt};
          word_nxt   = in_data_word & mm3_pkg::tail_mask(cnt[1:0]);
          last_nxt   = in_last;
          full_nxt   = cnt[2];
          in_msg_nxt = !in_last;
          if (cnt != 3'd0) begin
            state_nxt = mm3_pkg::ST_MIX1;
          end else if (in_last) begin
            state_nxt = mm3_pkg::ST_FIN1;
          end
        end
      end
      mm3_pkg::ST_MIX1: begin
        mul_req.en = 1'b1;
        mul_req.k  = mm3_pkg::K_C1;
        mul_req.a  = word_r;
        state_nxt  = mm3_pkg::ST_MIX2;
      end
      mm3_pkg::ST_MIX2: begin
        mul_req.en = 1'b1;
        mul_req.k  = mm3_pkg::K_C2;
        mul_req.a  = {prod[16:0], prod[31:17]};
        state_nxt  = full_r ? mm3_pkg::ST_MIX3 : mm3_pkg::ST_TAIL;
      end
      mm3_pkg::ST_MIX3: begin
        mul_req.en = 1'b1;
        mul_req.k  = mm3_pkg::K_MUL5;
        mul_req.a  = {mix_x[18:0], mix_x[31:19]};
        state_nxt  = mm3_pkg::ST_ADD;
      end
      mm3_pkg::ST_ADD: begin
        h_nxt     = prod + mm3_pkg::MIX_ADD;
        state_nxt = last_r ? mm3_pkg::ST_FIN1 : mm3_pkg::ST_IDLE;
      end
      mm3_pkg::ST_TAIL: begin
        h_nxt     = mix_x;
        state_nxt = last_r ? mm3_pkg::ST_FIN1 : mm3_pkg::ST_IDLE;
      end
      mm3_pkg::ST_FIN1: begin
        mul_req.en = 1'b1;
        mul_req.k  = mm3_pkg::K_F1;
        mul_req.a  = fin_a;
        state_nxt  = mm3_pkg::ST_FIN2;
      end
      mm3_pkg::ST_FIN2: begin
        mul_req.en = 1'b1;
        mul_req.k  = mm3_pkg::K_F2;
        mul_req.a  = fin_b;
        state_nxt  = mm3_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mm3_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    if (state_r == mm3_pkg::ST_FIN2) begin
      pend_nxt = 1'b1;
    end else if (pend_r && out_free) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mm3_pkg::ST_IDLE;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt || (pend_r && out_free);
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r      <= h_nxt;
    len_r    <= len_nxt;
    word_r   <= word_nxt;
    last_r   <= last_nxt;
    full_r   <= full_nxt;
    out_hash_r <= (pend_r && out_free) ? fin_h : out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  a_mix_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mm3_pkg::ST_MIX1 |=> state_r == mm3_pkg::ST_MIX2)
    else $error("mix step skipped");

  a_msg_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_msg_r == !$past(in_last))
    else $error("message flag not updated on item");

  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cnt == 3'd0 && !in_last |=> state_r == mm3_pkg::ST_IDLE)
    else $error("empty item started work");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_hash_r))
    else $error("stalled result lost");

endmodule
